[rtl/bcpmd_pkg.sv]
// Shared types, widths and constants for the balance cascade motor drive.
// Used by the multiply-accumulate unit, the sequencer, the top level and its checker.
package bcpmd_pkg;

    localparam int GAIN_W   = 16;
    localparam int FIELD_W  = 16;
    localparam int OPND_W   = 19;
    localparam int PROD_W   = GAIN_W + OPND_W;
    localparam int ACC_W    = 42;
    localparam int OUT_W    = 10;
    localparam int CFG_IDX_W = 3;

    localparam int DUTY_LIMIT_DEF = 990;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PROP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_INT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DERIV = 3'd4;

    localparam logic signed [GAIN_W-1:0] RST_ANGLE_GAIN  = 16'sd25600;
    localparam logic signed [GAIN_W-1:0] RST_RATE_GAIN   = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_SPEED_PROP  = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_SPEED_INT   = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_SPEED_DERIV = 16'sd0;

    typedef struct packed {
        logic signed [GAIN_W-1:0] angle_gain;
        logic signed [GAIN_W-1:0] rate_gain;
        logic signed [GAIN_W-1:0] speed_prop_gain;
        logic signed [GAIN_W-1:0] speed_int_gain;
        logic signed [GAIN_W-1:0] speed_deriv_gain;
    } t_gains;

    typedef struct packed {
        logic issue;
        logic shift;
        logic load;
    } t_mac_ctl;

endpackage

[rtl/bcpmd_mac.sv]
// Shared multiply-accumulate unit: one registered signed multiplier and an accumulator.
// Depends on bcpmd_pkg.
module bcpmd_mac
    import bcpmd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [GAIN_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    input  logic signed [ACC_W-1:0]  i_load_val,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_psh;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign addend   = r_psh ? (prod_ext <<< 8) : prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= i_a * i_b;
            r_psh  <= i_ctl.shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= i_load_val;
        end else if (r_pv) begin
            r_acc <= r_acc + addend;
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/bcpmd_seq.sv]
// Sequencer for the angle loop and both wheel loops: input capture, error history,
// duty accumulators and the result register. Depends on bcpmd_pkg; drives bcpmd_mac.
module bcpmd_seq
    import bcpmd_pkg::*;
#(
    parameter int DUTY_LIMIT = DUTY_LIMIT_DEF
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_gains                    i_gains,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [FIELD_W-1:0] i_tilt_angle,
    input  logic signed [FIELD_W-1:0] i_tilt_rate,
    input  logic signed [FIELD_W-1:0] i_left_speed,
    input  logic signed [FIELD_W-1:0] i_right_speed,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [OUT_W-1:0]          o_left_forward_duty,
    output logic [OUT_W-1:0]          o_left_reverse_duty,
    output logic [OUT_W-1:0]          o_right_forward_duty,
    output logic [OUT_W-1:0]          o_right_reverse_duty,
    output t_mac_ctl                  o_mac_ctl,
    output logic signed [GAIN_W-1:0]  o_mac_a,
    output logic signed [OPND_W-1:0]  o_mac_b,
    output logic signed [ACC_W-1:0]   o_mac_load,
    input  logic signed [ACC_W-1:0]   i_mac_acc
);

    localparam int DW = $clog2(DUTY_LIMIT + 1) + 1;
    localparam int QW = ACC_W - 8;
    localparam logic signed [QW-1:0] LIM_POS = QW'(DUTY_LIMIT);
    localparam logic signed [QW-1:0] LIM_NEG = -QW'(DUTY_LIMIT);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_A  = 4'd1;
    localparam logic [3:0] S_MUL_R  = 4'd2;
    localparam logic [3:0] S_WAIT_T = 4'd3;
    localparam logic [3:0] S_TGT    = 4'd4;
    localparam logic [3:0] S_ERR    = 4'd5;
    localparam logic [3:0] S_KP     = 4'd6;
    localparam logic [3:0] S_KI     = 4'd7;
    localparam logic [3:0] S_KD     = 4'd8;
    localparam logic [3:0] S_WAIT_D = 4'd9;
    localparam logic [3:0] S_DUTY   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    function automatic logic signed [FIELD_W-1:0] sat_t(input logic signed [25:0] v);
        if (v > 26'sd32767) begin
            return 16'sh7fff;
        end else if (v < -26'sd32768) begin
            return 16'sh8000;
        end
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat_e(input logic signed [16:0] v);
        if (v > 17'sd32767) begin
            return 16'sh7fff;
        end else if (v < -17'sd32768) begin
            return 16'sh8000;
        end
        return v[FIELD_W-1:0];
    endfunction

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic                      r_wheel;
    logic signed [FIELD_W-1:0] r_angle;
    logic signed [FIELD_W-1:0] r_rate;
    logic signed [FIELD_W-1:0] r_speed_l;
    logic signed [FIELD_W-1:0] r_speed_r;
    logic signed [FIELD_W-1:0] r_target;
    logic signed [FIELD_W-1:0] r_e0;
    logic signed [FIELD_W-1:0] r_err1_l;
    logic signed [FIELD_W-1:0] r_err2_l;
    logic signed [FIELD_W-1:0] r_err1_r;
    logic signed [FIELD_W-1:0] r_err2_r;
    logic signed [DW-1:0]      r_dacc_l;
    logic signed [DW-1:0]      r_dacc_r;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_lf;
    logic [OUT_W-1:0]          r_lr;
    logic [OUT_W-1:0]          r_rf;
    logic [OUT_W-1:0]          r_rr;

    logic signed [FIELD_W-1:0] e1;
    logic signed [FIELD_W-1:0] e2;
    logic signed [FIELD_W-1:0] speed;
    logic signed [DW-1:0]      dacc;
    logic signed [16:0]        diff;
    logic signed [OPND_W-1:0]  d1;
    logic signed [OPND_W-1:0]  d2;
    logic signed [ACC_W-1:0]   t_sum;
    logic signed [ACC_W-1:0]   d_sum;
    logic signed [QW-1:0]      d_q;
    logic signed [DW-1:0]      d_new;
    logic                      accept;
    logic                      out_free;
    logic [DW-1:0]             neg_l;
    logic [DW-1:0]             neg_r;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    assign e1    = r_wheel ? r_err1_r : r_err1_l;
    assign e2    = r_wheel ? r_err2_r : r_err2_l;
    assign speed = r_wheel ? r_speed_r : r_speed_l;
    assign dacc  = r_wheel ? r_dacc_r : r_dacc_l;

    assign diff = {r_target[FIELD_W-1], r_target} - {speed[FIELD_W-1], speed};
    assign d1   = OPND_W'(r_e0) - OPND_W'(e1);
    assign d2   = OPND_W'(r_e0) - (OPND_W'(e1) <<< 1) + OPND_W'(e2);

    assign t_sum = i_mac_acc + (i_mac_acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
    assign d_sum = i_mac_acc + (i_mac_acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
    assign d_q   = d_sum[ACC_W-1:8];

    always_comb begin
        if (d_q > LIM_POS) begin
            d_new = DW'(LIM_POS);
        end else if (d_q < LIM_NEG) begin
            d_new = DW'(LIM_NEG);
        end else begin
            d_new = DW'(d_q);
        end
    end

    assign o_mac_load = (r_state == S_MUL_A) ? '0
                      : {{(ACC_W-DW-8){dacc[DW-1]}}, dacc, 8'd0};

    always_comb begin
        o_mac_ctl = '0;
        o_mac_a   = i_gains.angle_gain;
        o_mac_b   = OPND_W'(r_angle);
        case (r_state)
            S_MUL_A: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_ctl.load  = 1'b1;
            end
            S_MUL_R: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_ctl.shift = 1'b1;
                o_mac_a = i_gains.rate_gain;
                o_mac_b = OPND_W'(r_rate);
            end
            S_ERR: begin
                o_mac_ctl.load = 1'b1;
            end
            S_KP: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_a = i_gains.speed_prop_gain;
                o_mac_b = d1;
            end
            S_KI: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_a = i_gains.speed_int_gain;
                o_mac_b = OPND_W'(r_e0);
            end
            S_KD: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_a = i_gains.speed_deriv_gain;
                o_mac_b = d2;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   n_state = accept ? S_MUL_A : S_IDLE;
            S_MUL_A:  n_state = S_MUL_R;
            S_MUL_R:  n_state = S_WAIT_T;
            S_WAIT_T: n_state = S_TGT;
            S_TGT:    n_state = S_ERR;
            S_ERR:    n_state = S_KP;
            S_KP:     n_state = S_KI;
            S_KI:     n_state = S_KD;
            S_KD:     n_state = S_WAIT_D;
            S_WAIT_D: n_state = S_DUTY;
            S_DUTY:   n_state = r_wheel ? S_OUT : S_ERR;
            S_OUT:    n_state = out_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= 1'b0;
            r_err1_l    <= '0;
            r_err2_l    <= '0;
            r_err1_r    <= '0;
            r_err2_r    <= '0;
            r_dacc_l    <= '0;
            r_dacc_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TGT) begin
                r_wheel <= 1'b0;
            end
            if (r_state == S_DUTY) begin
                r_wheel <= 1'b1;
                if (r_wheel) begin
                    r_err2_r <= r_err1_r;
                    r_err1_r <= r_e0;
                    r_dacc_r <= d_new;
                end else begin
                    r_err2_l <= r_err1_l;
                    r_err1_l <= r_e0;
                    r_dacc_l <= d_new;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign neg_l = -r_dacc_l;
    assign neg_r = -r_dacc_r;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_angle   <= i_tilt_angle;
            r_rate    <= i_tilt_rate;
            r_speed_l <= i_left_speed;
            r_speed_r <= i_right_speed;
        end
        if (r_state == S_TGT) begin
            r_target <= sat_t(t_sum[ACC_W-1:16]);
        end
        if (r_state == S_ERR) begin
            r_e0 <= sat_e(diff);
        end
        if (r_state == S_OUT && out_free) begin
            r_lf <= r_dacc_l[DW-1] ? '0 : OUT_W'(unsigned'(r_dacc_l));
            r_lr <= r_dacc_l[DW-1] ? OUT_W'(neg_l) : '0;
            r_rf <= r_dacc_r[DW-1] ? '0 : OUT_W'(unsigned'(r_dacc_r));
            r_rr <= r_dacc_r[DW-1] ? OUT_W'(neg_r) : '0;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_left_forward_duty  = r_lf;
    assign o_left_reverse_duty  = r_lr;
    assign o_right_forward_duty = r_rf;
    assign o_right_reverse_duty = r_rr;

endmodule

[rtl/balance_cascade_pid_motor_drive.sv]
// Balance robot cascade controller: PD angle loop feeding two incremental PID speed loops.
//   Input channel (i_valid/o_ready) carries one control tick: tilt angle (Q8.8 degrees),
//   gyro rate and both wheel encoder counts. Output channel (o_valid/i_ready) returns
//   the forward and reverse H-bridge compare values for each wheel, one result per tick.
//   Configuration channel (i_cfg_valid/o_cfg_ready) writes the five Q8.8 gains by index:
//   0 angle, 1 rate, 2 speed proportional, 3 speed integral, 4 speed derivative.
//   Writes to other indexes are dropped. Write only while the block is idle.
// Timing:
//   A tick is stepped from its transfer to the result register; the block then returns
//   to idle, and only there takes the next tick. All products go through
//   a single 16x19 multiplier with an accumulator, stepped by a sequencer: two products
//   for the target speed, three per wheel.
// Reset:
//   Synchronous active-low reset restores the default gains, clears the error history
//   and the duty accumulators, and empties the result register.
// Backpressure:
//   A finished result waits in the output register; a new tick is taken meanwhile.
//   If the previous result is still untaken when the next completes, the block holds
//   until the output transfer.
// Depends on bcpmd_pkg, bcpmd_mac and bcpmd_seq.
module balance_cascade_pid_motor_drive
    import bcpmd_pkg::*;
#(
    parameter int DUTY_LIMIT = DUTY_LIMIT_DEF
)
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [FIELD_W-1:0]   i_tilt_angle,
    input  logic signed [FIELD_W-1:0]   i_tilt_rate,
    input  logic signed [FIELD_W-1:0]   i_left_speed,
    input  logic signed [FIELD_W-1:0]   i_right_speed,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [OUT_W-1:0]            o_left_forward_duty,
    output logic [OUT_W-1:0]            o_left_reverse_duty,
    output logic [OUT_W-1:0]            o_right_forward_duty,
    output logic [OUT_W-1:0]            o_right_reverse_duty,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [GAIN_W-1:0]           i_cfg_data
);

    t_gains                   r_gains;
    t_mac_ctl                 mac_ctl;
    logic signed [GAIN_W-1:0] mac_a;
    logic signed [OPND_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  mac_load;
    logic signed [ACC_W-1:0]  mac_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.angle_gain       <= RST_ANGLE_GAIN;
            r_gains.rate_gain        <= RST_RATE_GAIN;
            r_gains.speed_prop_gain  <= RST_SPEED_PROP;
            r_gains.speed_int_gain   <= RST_SPEED_INT;
            r_gains.speed_deriv_gain <= RST_SPEED_DERIV;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ANGLE_GAIN:  r_gains.angle_gain       <= signed'(i_cfg_data);
                CFG_RATE_GAIN:   r_gains.rate_gain        <= signed'(i_cfg_data);
                CFG_SPEED_PROP:  r_gains.speed_prop_gain  <= signed'(i_cfg_data);
                CFG_SPEED_INT:   r_gains.speed_int_gain   <= signed'(i_cfg_data);
                CFG_SPEED_DERIV: r_gains.speed_deriv_gain <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    bcpmd_seq #(
        .DUTY_LIMIT(DUTY_LIMIT)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_gains             (r_gains),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_tilt_angle        (i_tilt_angle),
        .i_tilt_rate         (i_tilt_rate),
        .i_left_speed        (i_left_speed),
        .i_right_speed       (i_right_speed),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_left_forward_duty (o_left_forward_duty),
        .o_left_reverse_duty (o_left_reverse_duty),
        .o_right_forward_duty(o_right_forward_duty),
        .o_right_reverse_duty(o_right_reverse_duty),
        .o_mac_ctl           (mac_ctl),
        .o_mac_a             (mac_a),
        .o_mac_b             (mac_b),
        .o_mac_load          (mac_load),
        .i_mac_acc           (mac_acc)
    );

    bcpmd_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_a       (mac_a),
        .i_b       (mac_b),
        .i_load_val(mac_load),
        .o_acc     (mac_acc)
    );

endmodule

[rtl/bcpmd_chk.sv]
// Port-level checker for the balance cascade motor drive, bound to the top level.
// Depends on bcpmd_pkg.
module bcpmd_chk
    import bcpmd_pkg::*;
#(
    parameter int DUTY_LIMIT = DUTY_LIMIT_DEF
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      o_ready,
    input  logic                      o_valid,
    input  logic                      i_ready,
    input  logic [OUT_W-1:0]          o_left_forward_duty,
    input  logic [OUT_W-1:0]          o_left_reverse_duty,
    input  logic [OUT_W-1:0]          o_right_forward_duty,
    input  logic [OUT_W-1:0]          o_right_reverse_duty
);

    localparam logic [OUT_W-1:0] LIM = OUT_W'(DUTY_LIMIT);

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready ##1 !o_ready)
        else $error("input taken while a tick is in progress");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_left_forward_duty)
            && $stable(o_left_reverse_duty) && $stable(o_right_forward_duty)
            && $stable(o_right_reverse_duty)))
        else $error("stalled result changed");

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_left_forward_duty == '0 || o_left_reverse_duty == '0)
            && (o_right_forward_duty == '0 || o_right_reverse_duty == '0)))
        else $error("both bridge directions driven");

    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_forward_duty <= LIM && o_left_reverse_duty <= LIM
            && o_right_forward_duty <= LIM && o_right_reverse_duty <= LIM))
        else $error("duty above limit");

endmodule

bind balance_cascade_pid_motor_drive bcpmd_chk #(.DUTY_LIMIT(DUTY_LIMIT)) u_chk (.*);

[tb/tb.sv]
// Self-checking bench for balance_cascade_pid_motor_drive: directed and random control ticks,
// gain writes through the config channel, random idling on both channels and a long output hold.
// Depends on bcpmd_pkg and the block's RTL; expected duties come from an in-bench predictor.
module tb;
    import bcpmd_pkg::*;

    localparam int MAX_CFG_INDEX = (1 << CFG_IDX_W) - 1;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic signed [FIELD_W-1:0] angle;
        logic signed [FIELD_W-1:0] rate;
        logic signed [FIELD_W-1:0] lspeed;
        logic signed [FIELD_W-1:0] rspeed;
    } t_tick;

    typedef struct {
        logic [OUT_W-1:0] lfwd;
        logic [OUT_W-1:0] lrev;
        logic [OUT_W-1:0] rfwd;
        logic [OUT_W-1:0] rrev;
    } t_duty_set;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic signed [FIELD_W-1:0] i_tilt_angle  = '0;
    logic signed [FIELD_W-1:0] i_tilt_rate   = '0;
    logic signed [FIELD_W-1:0] i_left_speed  = '0;
    logic signed [FIELD_W-1:0] i_right_speed = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic [OUT_W-1:0]          o_left_forward_duty;
    logic [OUT_W-1:0]          o_left_reverse_duty;
    logic [OUT_W-1:0]          o_right_forward_duty;
    logic [OUT_W-1:0]          o_right_reverse_duty;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index   = '0;
    logic [GAIN_W-1:0]         i_cfg_data    = '0;

    logic signed [GAIN_W-1:0]  gain_reg [0:4];
    logic signed [FIELD_W-1:0] err_last [0:1];
    logic signed [FIELD_W-1:0] err_older [0:1];
    logic signed [10:0]        duty_acc [0:1];

    t_duty_set duty_queue [$];
    int        errors      = 0;
    bit        tx_idle_on  = 1'b1;
    logic      rx_idle_on  = 1'b1;
    logic      hold_req    = 1'b0;
    int        hold_left   = 0;

    balance_cascade_pid_motor_drive i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_tilt_angle         (i_tilt_angle),
        .i_tilt_rate          (i_tilt_rate),
        .i_left_speed         (i_left_speed),
        .i_right_speed        (i_right_speed),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_left_forward_duty  (o_left_forward_duty),
        .o_left_reverse_duty  (o_left_reverse_duty),
        .o_right_forward_duty (o_right_forward_duty),
        .o_right_reverse_duty (o_right_reverse_duty),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint clamp_s16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Update one wheel's error history and accumulator; return the new signed duty.
    function automatic longint wheel_update(input int w, input longint target,
                                            input longint speed);
        longint e0, e1, e2, inc, d;
        e0 = clamp_s16(target - speed);
        e1 = longint'(err_last[w]);
        e2 = longint'(err_older[w]);
        inc = longint'(gain_reg[CFG_SPEED_PROP]) * (e0 - e1)
            + longint'(gain_reg[CFG_SPEED_INT]) * e0
            + longint'(gain_reg[CFG_SPEED_DERIV]) * (e0 - 2 * e1 + e2);
        d = (longint'(duty_acc[w]) * 256 + inc) / 256;
        if (d > DUTY_LIMIT_DEF) d = DUTY_LIMIT_DEF;
        else if (d < -DUTY_LIMIT_DEF) d = -DUTY_LIMIT_DEF;
        err_older[w] = err_last[w];
        err_last[w]  = FIELD_W'(e0);
        duty_acc[w]  = 11'(d);
        return d;
    endfunction

    function automatic t_duty_set advance_drive(input t_tick t);
        longint    sum, target, dl, dr;
        t_duty_set r;
        sum = longint'(gain_reg[CFG_ANGLE_GAIN]) * longint'(t.angle)
            + longint'(gain_reg[CFG_RATE_GAIN]) * longint'(t.rate) * 256;
        target = clamp_s16(sum / 65536);
        dl = wheel_update(0, target, longint'(t.lspeed));
        dr = wheel_update(1, target, longint'(t.rspeed));
        r.lfwd = (dl >= 0) ? OUT_W'(dl) : '0;
        r.lrev = (dl < 0) ? OUT_W'(-dl) : '0;
        r.rfwd = (dr >= 0) ? OUT_W'(dr) : '0;
        r.rrev = (dr < 0) ? OUT_W'(-dr) : '0;
        return r;
    endfunction

    function automatic t_tick make_tick(input int a, input int b, input int c, input int d);
        t_tick t;
        t.angle  = FIELD_W'(a);
        t.rate   = FIELD_W'(b);
        t.lspeed = FIELD_W'(c);
        t.rspeed = FIELD_W'(d);
        return t;
    endfunction

    function automatic int rand_field(input int span);
        if ($urandom_range(3) == 0) return int'($signed(FIELD_W'($urandom)));
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_gain(input int span);
        case ($urandom_range(5))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    task automatic send_tick(input t_tick t);
        t_duty_set exp_d;
        if (tx_idle_on && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_tilt_angle  <= t.angle;
        i_tilt_rate   <= t.rate;
        i_left_speed  <= t.lspeed;
        i_right_speed <= t.rspeed;
        do @(posedge i_clk); while (!o_ready);
        exp_d = advance_drive(t);
        duty_queue.push_back(exp_d);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline go quiet.
    task automatic settle();
        int n;
        n = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (duty_queue.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input int idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= GAIN_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= int'(CFG_SPEED_DERIV)) gain_reg[idx] = GAIN_W'(data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_gains(input int ag, input int rg, input int pg, input int ig,
                             input int dg);
        write_gain(CFG_ANGLE_GAIN, ag);
        write_gain(CFG_RATE_GAIN, rg);
        write_gain(CFG_SPEED_PROP, pg);
        write_gain(CFG_SPEED_INT, ig);
        write_gain(CFG_SPEED_DERIV, dg);
    endtask

    task automatic test_reset_gains();
        send_tick(make_tick(0, 0, 0, 0));
        send_tick(make_tick(32767, 0, -32768, 32767));
        send_tick(make_tick(-32768, 0, 32767, -32768));
        send_tick(make_tick(256, 0, 100, 100));
        send_tick(make_tick(1, -1, 1, -1));
        send_tick(make_tick(-1, 32767, -1, 0));
    endtask

    task automatic test_gain_extremes();
        settle();
        set_gains(32767, 32767, 32767, 32767, 32767);
        send_tick(make_tick(32767, 32767, 0, 0));
        send_tick(make_tick(-32768, -32768, 0, 0));
        send_tick(make_tick(-1, -1, -32768, 32767));
        settle();
        set_gains(-32768, -32768, -32768, -32768, -32768);
        send_tick(make_tick(32767, 32767, 32767, -32768));
        send_tick(make_tick(-32768, -32768, -32768, 32767));
        send_tick(make_tick(0, 0, 0, 0));
    endtask

    task automatic test_unmapped_index();
        int i;
        settle();
        set_gains(RST_ANGLE_GAIN, 64, -128, RST_SPEED_INT, 32);
        for (i = int'(CFG_SPEED_DERIV) + 1; i <= MAX_CFG_INDEX; i++) write_gain(i, 16'h8001);
        send_tick(make_tick(1200, -300, 40, -40));
        send_tick(make_tick(-700, 250, -10, 90));
        send_tick(make_tick(0, 0, 0, 0));
    endtask

    task automatic test_zero_duty();
        settle();
        set_gains(0, 0, 0, RST_SPEED_INT, 0);
        send_tick(make_tick(0, 0, int'(duty_acc[0]), int'(duty_acc[1])));
        settle();
        write_gain(CFG_SPEED_INT, 1);
        send_tick(make_tick(0, 0, 255, -255));
        send_tick(make_tick(0, 0, 255, -255));
    endtask

    task automatic test_random_traffic();
        int p, n;
        for (p = 0; p < 8; p++) begin
            settle();
            if (p == 0) set_gains(32767, 32767, 32767, 32767, 32767);
            else if (p == 1) set_gains(-32768, -32768, -32768, -32768, -32768);
            else set_gains(pick_gain(32000), pick_gain(512), pick_gain(512),
                           pick_gain(512), pick_gain(256));
            tx_idle_on = (p != 3);
            rx_idle_on <= (p != 3);
            for (n = 0; n < 200; n++)
                send_tick(make_tick(rand_field(2000), rand_field(500), rand_field(400),
                                    rand_field(400)));
        end
    endtask

    task automatic test_output_hold();
        int n;
        settle();
        set_gains(RST_ANGLE_GAIN, 128, 256, RST_SPEED_INT, 64);
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        hold_req   <= 1'b1;
        for (n = 0; n < 40; n++)
            send_tick(make_tick(rand_field(2000), rand_field(500), rand_field(400),
                                rand_field(400)));
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (rx_idle_on && $urandom_range(99) < 17) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_duty_set e;
        if (i_rst_n && o_valid && i_ready) begin
            if (duty_queue.size() == 0) begin
                flag_error("result transfer with no expected duty pending");
            end else begin
                e = duty_queue.pop_front();
                if (o_left_forward_duty !== e.lfwd)
                    flag_error($sformatf("left forward %0d, expected %0d",
                                         o_left_forward_duty, e.lfwd));
                if (o_left_reverse_duty !== e.lrev)
                    flag_error($sformatf("left reverse %0d, expected %0d",
                                         o_left_reverse_duty, e.lrev));
                if (o_right_forward_duty !== e.rfwd)
                    flag_error($sformatf("right forward %0d, expected %0d",
                                         o_right_forward_duty, e.rfwd));
                if (o_right_reverse_duty !== e.rrev)
                    flag_error($sformatf("right reverse %0d, expected %0d",
                                         o_right_reverse_duty, e.rrev));
            end
        end
    end

    initial begin
        gain_reg[CFG_ANGLE_GAIN]  = RST_ANGLE_GAIN;
        gain_reg[CFG_RATE_GAIN]   = RST_RATE_GAIN;
        gain_reg[CFG_SPEED_PROP]  = RST_SPEED_PROP;
        gain_reg[CFG_SPEED_INT]   = RST_SPEED_INT;
        gain_reg[CFG_SPEED_DERIV] = RST_SPEED_DERIV;
        err_last[0]  = '0;
        err_last[1]  = '0;
        err_older[0] = '0;
        err_older[1] = '0;
        duty_acc[0]  = '0;
        duty_acc[1]  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_reset_gains();
        test_gain_extremes();
        test_unmapped_index();
        test_zero_duty();
        test_random_traffic();
        test_output_hold();
        settle();
        if (duty_queue.size() != 0)
            flag_error($sformatf("%0d expected duties never arrived", duty_queue.size()));
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/bcpmd_pkg.sv
rtl/bcpmd_mac.sv
rtl/bcpmd_seq.sv
rtl/balance_cascade_pid_motor_drive.sv
rtl/bcpmd_chk.sv
tb/tb.sv
